FILE: hw/rtl/rbmc_pkg.sv
// ----------------------------------------------------------------------------
// rbmc_pkg: shared types and constants for the RGB blend / matte / chroma key
// compositor. Pixel request and result layouts, register map, mode codes.
// ----------------------------------------------------------------------------
package rbmc_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned ALPHA_W  = 9;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IN_W     = 64;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned PIX_IN_W = 6 * CHAN_W + ALPHA_W;

  localparam logic [ALPHA_W-1:0] FULL_WEIGHT = 9'd256;

  typedef enum logic [1:0] {
    MODE_BLEND = 2'd0,
    MODE_MATTE = 2'd1,
    MODE_KEY   = 2'd2,
    MODE_PASS  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_ALPHA     = 3'd1,
    REG_KEY_RED   = 3'd2,
    REG_KEY_GREEN = 3'd3,
    REG_KEY_BLUE  = 3'd4,
    REG_KEY_TOL   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    mode_t               mode;
    logic [ALPHA_W-1:0]  blend_alpha;
    logic [CHAN_W-1:0]   key_red;
    logic [CHAN_W-1:0]   key_green;
    logic [CHAN_W-1:0]   key_blue;
    logic [CHAN_W-1:0]   key_tolerance;
  } cfg_t;

  // base_red sits in the lowest bits
  typedef struct packed {
    logic [ALPHA_W-1:0] matte_alpha;
    logic [CHAN_W-1:0]  over_blue;
    logic [CHAN_W-1:0]  over_green;
    logic [CHAN_W-1:0]  over_red;
    logic [CHAN_W-1:0]  base_blue;
    logic [CHAN_W-1:0]  base_green;
    logic [CHAN_W-1:0]  base_red;
  } pix_in_t;

  typedef struct packed {
    logic               alpha_error;
    logic [CHAN_W-1:0]  out_blue;
    logic [CHAN_W-1:0]  out_green;
    logic [CHAN_W-1:0]  out_red;
  } pix_out_t;

endpackage

FILE: hw/rtl/rbmc_cfg.sv
// ----------------------------------------------------------------------------
// rbmc_cfg: configuration register file
// APB-style slave holding mode, constant alpha and chroma key settings.
// ----------------------------------------------------------------------------
module rbmc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rbmc_pkg::ADDR_W-1:0]         paddr,
  input  logic [rbmc_pkg::DATA_W-1:0]         pwdata,
  output logic [rbmc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  output rbmc_pkg::cfg_t                      cfg
);
  import rbmc_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_BLEND;
      cfg.blend_alpha   <= 9'd128;
      cfg.key_red       <= '0;
      cfg.key_green     <= '0;
      cfg.key_blue      <= '0;
      cfg.key_tolerance <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:      cfg.mode          <= mode_t'(pwdata[1:0]);
        REG_ALPHA:     cfg.blend_alpha   <= pwdata[ALPHA_W-1:0];
        REG_KEY_RED:   cfg.key_red       <= pwdata[CHAN_W-1:0];
        REG_KEY_GREEN: cfg.key_green     <= pwdata[CHAN_W-1:0];
        REG_KEY_BLUE:  cfg.key_blue      <= pwdata[CHAN_W-1:0];
        REG_KEY_TOL:   cfg.key_tolerance <= pwdata[CHAN_W-1:0];
        default: ;     // unmapped slots ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:      prdata = DATA_W'(cfg.mode);
      REG_ALPHA:     prdata = DATA_W'(cfg.blend_alpha);
      REG_KEY_RED:   prdata = DATA_W'(cfg.key_red);
      REG_KEY_GREEN: prdata = DATA_W'(cfg.key_green);
      REG_KEY_BLUE:  prdata = DATA_W'(cfg.key_blue);
      REG_KEY_TOL:   prdata = DATA_W'(cfg.key_tolerance);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/rbmc_mix.sv
// ----------------------------------------------------------------------------
// rbmc_mix: pixel combine datapath
// Constant blend, matte blend with range check, chroma key select, pass-through.
// ----------------------------------------------------------------------------
module rbmc_mix (
  input  rbmc_pkg::cfg_t     cfg,
  input  rbmc_pkg::pix_in_t  pix,
  output rbmc_pkg::pix_out_t res
);
  import rbmc_pkg::*;

  // (b*(256-a) + o*a) >> 8; sum stays below 2^16 for a <= 256
  function automatic logic [CHAN_W-1:0] mix_ch(input logic [CHAN_W-1:0]  b,
                                               input logic [CHAN_W-1:0]  o,
                                               input logic [ALPHA_W-1:0] a);
    logic [ALPHA_W-1:0] w;
    logic [16:0]        p;
    w = FULL_WEIGHT - a;
    p = 17'(b) * 17'(w) + 17'(o) * 17'(a);
    return p[15:8];
  endfunction

  function automatic logic near_key(input logic [CHAN_W-1:0] v,
                                    input logic [CHAN_W-1:0] k,
                                    input logic [CHAN_W-1:0] tol);
    logic [CHAN_W-1:0] d;
    d = (v >= k) ? (v - k) : (k - v);
    return d <= tol;
  endfunction

  logic [ALPHA_W-1:0] weight;
  logic               matte_bad;
  logic               key_hit;
  logic [CHAN_W-1:0]  mr, mg, mb;

  always_comb begin
    matte_bad = pix.matte_alpha > FULL_WEIGHT;
    if (cfg.mode == MODE_MATTE) begin
      weight = pix.matte_alpha;
    end else begin
      weight = (cfg.blend_alpha > FULL_WEIGHT) ? FULL_WEIGHT : cfg.blend_alpha;
    end
    mr = mix_ch(pix.base_red,   pix.over_red,   weight);
    mg = mix_ch(pix.base_green, pix.over_green, weight);
    mb = mix_ch(pix.base_blue,  pix.over_blue,  weight);
    key_hit = near_key(pix.base_red,   cfg.key_red,   cfg.key_tolerance) &&
              near_key(pix.base_green, cfg.key_green, cfg.key_tolerance) &&
              near_key(pix.base_blue,  cfg.key_blue,  cfg.key_tolerance);

    res.alpha_error = 1'b0;
    res.out_red     = pix.base_red;
    res.out_green   = pix.base_green;
    res.out_blue    = pix.base_blue;
    unique case (cfg.mode)
      MODE_BLEND: begin
        res.out_red   = mr;
        res.out_green = mg;
        res.out_blue  = mb;
      end
      MODE_MATTE: begin
        if (matte_bad) begin
          res.alpha_error = 1'b1;
          res.out_red     = '0;
          res.out_green   = '0;
          res.out_blue    = '0;
        end else begin
          res.out_red   = mr;
          res.out_green = mg;
          res.out_blue  = mb;
        end
      end
      MODE_KEY: begin
        if (key_hit) begin
          res.out_red   = pix.over_red;
          res.out_green = pix.over_green;
          res.out_blue  = pix.over_blue;
        end
      end
      MODE_PASS: ;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/rgb_blend_matte_chromakey.sv
// ----------------------------------------------------------------------------
// rgb_blend_matte_chromakey: RGB pixel compositor
// Alpha blend, per-pixel matte blend, chroma key and pass-through on a pixel stream.
// ----------------------------------------------------------------------------
// An accepted input request passes the input register, then the result register, to m_*.
// Throughput: one pixel per cycle; the input register and the result register
//   form a two-entry pipeline: while a result waits, one more request is taken
//   into the input register, then s_tready drops until m_tready returns.
// Reset: rst (synchronous) empties both stages and loads the register reset
//   values: mode constant blend, blend_alpha 128, key colour and tolerance 0.
module rgb_blend_matte_chromakey (
  input  logic                          clk,
  input  logic                          rst,
  // input pixel request
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] base_red, [15:8] base_green, [23:16] base_blue, [31:24] over_red,
  // [39:32] over_green, [47:40] over_blue, [56:48] matte_alpha, [63:57] zero
  input  logic [rbmc_pkg::IN_W-1:0]     s_tdata,
  // result request
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic [rbmc_pkg::OUT_W-1:0]    m_tdata,
  // [0] alpha_error
  output logic                          m_tuser,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbmc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rbmc_pkg::DATA_W-1:0]   pwdata,
  output logic [rbmc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import rbmc_pkg::*;

  cfg_t     cfg;
  pix_in_t  in_pix;     // input register
  logic     in_valid;
  pix_out_t mix_res;    // combinational result of the datapath
  pix_out_t out_pix;    // result register
  logic     out_valid;
  logic     stage_ready;

  rbmc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbmc_mix u_mix (
    .cfg (cfg),
    .pix (in_pix),
    .res (mix_res)
  );

  // Result register can load when it is empty or being drained this cycle;
  // the input register can load when it is empty or moving forward.
  assign stage_ready = !out_valid || m_tready;
  assign s_tready    = !in_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (stage_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pix <= pix_in_t'(s_tdata[PIX_IN_W-1:0]);
    end
    if (stage_ready && in_valid) begin
      out_pix <= mix_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_pix.out_blue, out_pix.out_green, out_pix.out_red};
  assign m_tuser  = out_pix.alpha_error;

endmodule

FILE: hw/rtl/rbmc_chk.sv
// ----------------------------------------------------------------------------
// rbmc_chk: port-level checks for the compositor
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module rbmc_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [rbmc_pkg::OUT_W-1:0]  m_tdata,
  input logic                        m_tuser
);
  import rbmc_pkg::*;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an alpha error result carries a black pixel
  a_err_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("alpha error with nonzero pixel");

  // with the result register empty the input side must take requests
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rgb_blend_matte_chromakey rbmc_chk u_rbmc_chk (.*);

FILE: tb/sv/tb_rgb_blend_matte_chromakey.sv
// ----------------------------------------------------------------------------
// tb_rgb_blend_matte_chromakey: self-checking bench for the pixel compositor
// Streams base/overlay pixel requests through constant blend, matte blend,
// chroma key and pass-through settings. Each result is checked against a
// local prediction, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_rgb_blend_matte_chromakey;
  import rbmc_pkg::*;

  localparam int unsigned HALF_PERIOD     = 10;
  localparam int unsigned LIMIT_CYCLES    = 250000;
  localparam int unsigned N_PHASES        = 12;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned REG_COUNT       = 6;    // first index past the register map

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // [7:0] base_red, [15:8] base_green, [23:16] base_blue, [31:24] over_red,
  // [39:32] over_green, [47:40] over_blue, [56:48] matte_alpha, [63:57] zero
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  logic [OUT_W-1:0]  m_tdata;
  // [0] alpha_error
  logic              m_tuser;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // pixel requests not yet taken, and predicted results not yet seen
  pix_in_t  pix_pending_q[$];
  pix_out_t pix_expect_q[$];

  // register copy used by the predictor
  cfg_t cfg_now;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_sent         = 0;
  int n_checked      = 0;
  int n_flagged      = 0;
  int n_errors       = 0;
  int n_settings     = 0;
  int cycles         = 0;

  rgb_blend_matte_chromakey uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // (b*(256-a) + o*a) >> 8, truncated to a channel
  function automatic logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] b,
                                                    logic [CHAN_W-1:0] o,
                                                    logic [ALPHA_W-1:0] a);
    int unsigned acc;
    acc = int'(b) * (int'(FULL_WEIGHT) - int'(a)) + int'(o) * int'(a);
    return CHAN_W'(acc >> 8);
  endfunction

  // plain absolute distance, no wrap
  function automatic bit near_key(logic [CHAN_W-1:0] v, logic [CHAN_W-1:0] k);
    int d;
    d = (v >= k) ? int'(v) - int'(k) : int'(k) - int'(v);
    return d <= int'(cfg_now.key_tolerance);
  endfunction

  function automatic pix_out_t composite_pixel(pix_in_t px);
    pix_out_t           res;
    logic [ALPHA_W-1:0] wt;
    res.out_red     = px.base_red;
    res.out_green   = px.base_green;
    res.out_blue    = px.base_blue;
    res.alpha_error = 1'b0;
    case (cfg_now.mode)
      MODE_BLEND: begin
        // constant weight above full saturates
        wt = (cfg_now.blend_alpha > FULL_WEIGHT) ? FULL_WEIGHT : cfg_now.blend_alpha;
        res.out_red   = mix_channel(px.base_red, px.over_red, wt);
        res.out_green = mix_channel(px.base_green, px.over_green, wt);
        res.out_blue  = mix_channel(px.base_blue, px.over_blue, wt);
      end
      MODE_MATTE: begin
        if (px.matte_alpha > FULL_WEIGHT) begin
          // oversized matte: flag and black pixel
          res.alpha_error = 1'b1;
          res.out_red     = '0;
          res.out_green   = '0;
          res.out_blue    = '0;
        end else begin
          res.out_red   = mix_channel(px.base_red, px.over_red, px.matte_alpha);
          res.out_green = mix_channel(px.base_green, px.over_green, px.matte_alpha);
          res.out_blue  = mix_channel(px.base_blue, px.over_blue, px.matte_alpha);
        end
      end
      MODE_KEY: begin
        if (near_key(px.base_red, cfg_now.key_red) &&
            near_key(px.base_green, cfg_now.key_green) &&
            near_key(px.base_blue, cfg_now.key_blue)) begin
          res.out_red   = px.over_red;
          res.out_green = px.over_green;
          res.out_blue  = px.over_blue;
        end
      end
      default: ;  // unused mode: base passes through
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the head of the pending queue, holds it until taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pix_expect_q.push_back(composite_pixel(pix_in_t'(s_tdata[PIX_IN_W-1:0])));
        void'(pix_pending_q.pop_front());
        n_sent++;
      end
      if (s_tvalid && !s_tready) begin
        // request still waiting, keep valid and data as they are
      end else if (pix_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-PIX_IN_W){1'b0}}, pix_pending_q[0]};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: random back-pressure, then compare each result with the oldest
  // prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v !== got_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    pix_out_t got;
    pix_out_t exp_px;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (got.alpha_error) n_flagged++;
      if (pix_expect_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, expected none, actual %0h",
                 $time, got);
      end else begin
        exp_px = pix_expect_q.pop_front();
        check_field("out_red", exp_px.out_red, got.out_red);
        check_field("out_green", exp_px.out_green, got.out_green);
        check_field("out_blue", exp_px.out_blue, got.out_blue);
        check_field("alpha_error", exp_px.alpha_error, got.alpha_error);
        n_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_rgb_blend_matte_chromakey: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Register access and stimulus helpers
  // --------------------------------------------------------------------------

  // setup cycle, access cycle; register lands on the edge with pready high
  task automatic reg_write(input int unsigned idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MODE:      cfg_now.mode          = mode_t'(value[1:0]);
      REG_ALPHA:     cfg_now.blend_alpha   = value[ALPHA_W-1:0];
      REG_KEY_RED:   cfg_now.key_red       = value[CHAN_W-1:0];
      REG_KEY_GREEN: cfg_now.key_green     = value[CHAN_W-1:0];
      REG_KEY_BLUE:  cfg_now.key_blue      = value[CHAN_W-1:0];
      REG_KEY_TOL:   cfg_now.key_tolerance = value[CHAN_W-1:0];
      default: ;  // outside the map: no effect
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // all six registers; junk fills the unused upper bits
  task automatic write_settings(input mode_t m, input logic [ALPHA_W-1:0] alpha,
                                input logic [CHAN_W-1:0] kr, input logic [CHAN_W-1:0] kg,
                                input logic [CHAN_W-1:0] kb, input logic [CHAN_W-1:0] tol,
                                input logic [DATA_W-1:0] junk);
    reg_write(REG_MODE,      {junk[DATA_W-1:2], m});
    reg_write(REG_ALPHA,     {junk[DATA_W-1:ALPHA_W], alpha});
    reg_write(REG_KEY_RED,   {junk[DATA_W-1:CHAN_W], kr});
    reg_write(REG_KEY_GREEN, {junk[DATA_W-1:CHAN_W], kg});
    reg_write(REG_KEY_BLUE,  {junk[DATA_W-1:CHAN_W], kb});
    reg_write(REG_KEY_TOL,   {junk[DATA_W-1:CHAN_W], tol});
    n_settings++;
  endtask

  // every request taken and every result seen, then a quiet settle period
  task automatic wait_drained();
    while (pix_pending_q.size() != 0 || pix_expect_q.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic pix_in_t make_pixel(logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                                         logic [7:0] orr, logic [7:0] og, logic [7:0] ob,
                                         logic [8:0] ma);
    pix_in_t px;
    px.base_red    = br;
    px.base_green  = bg;
    px.base_blue   = bb;
    px.over_red    = orr;
    px.over_green  = og;
    px.over_blue   = ob;
    px.matte_alpha = ma;
    return px;
  endfunction

  // channel value within tolerance+2 of the key, clamped to the channel range
  function automatic logic [CHAN_W-1:0] near_value(logic [CHAN_W-1:0] k,
                                                   logic [CHAN_W-1:0] tol);
    int v;
    v = int'(k) + int'($urandom_range(2 * tol + 4)) - (int'(tol) + 2);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int                  phase;
    int                  i;
    mode_t               m;
    logic [ALPHA_W-1:0]  alpha;
    logic [CHAN_W-1:0]   tol;
    pix_in_t             px;

    cfg_now.mode          = MODE_BLEND;
    cfg_now.blend_alpha   = 9'd128;
    cfg_now.key_red       = '0;
    cfg_now.key_green     = '0;
    cfg_now.key_blue      = '0;
    cfg_now.key_tolerance = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: constant blend at half weight
    pix_pending_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF));
    pix_pending_q.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9'h000));
    pix_pending_q.push_back(make_pixel(8'h10, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'h10, 9'h0AA));
    wait_drained();

    // full weight: overlay only
    write_settings(MODE_BLEND, 9'd256, 8'h00, 8'h00, 8'h00, 8'h00, '0);
    pix_pending_q.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 9'h000));
    pix_pending_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 9'h100));
    wait_drained();
    // zero weight: base only
    reg_write(REG_ALPHA, 32'd0);
    pix_pending_q.push_back(make_pixel(8'hFF, 8'h01, 8'h80, 8'h00, 8'hFE, 8'h7F, 9'h155));
    wait_drained();
    // constant weight beyond full saturates
    reg_write(REG_ALPHA, 32'd511);
    pix_pending_q.push_back(make_pixel(8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD, 8'hEF, 9'h000));
    wait_drained();
    reg_write(REG_ALPHA, 32'd300);
    pix_pending_q.push_back(make_pixel(8'hFF, 8'h00, 8'h55, 8'h00, 8'hFF, 8'hAA, 9'h000));
    wait_drained();

    // matte: zero, full, just over full, max, mid weight
    write_settings(MODE_MATTE, 9'd128, 8'h00, 8'h00, 8'h00, 8'h00, '1);
    pix_pending_q.push_back(make_pixel(8'hC8, 8'h64, 8'h32, 8'h10, 8'h20, 8'h30, 9'd0));
    pix_pending_q.push_back(make_pixel(8'hC8, 8'h64, 8'h32, 8'h10, 8'h20, 8'h30, 9'd256));
    pix_pending_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'd257));
    pix_pending_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'd511));
    pix_pending_q.push_back(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 9'd128));
    wait_drained();

    // chroma key: exact, both tolerance edges, one step outside on red and on blue
    write_settings(MODE_KEY, 9'd128, 8'd10, 8'd200, 8'd30, 8'd5, '0);
    pix_pending_q.push_back(make_pixel(8'd10, 8'd200, 8'd30, 8'h11, 8'h22, 8'h33, 9'h1FF));
    pix_pending_q.push_back(make_pixel(8'd15, 8'd205, 8'd35, 8'h44, 8'h55, 8'h66, 9'h000));
    pix_pending_q.push_back(make_pixel(8'd5, 8'd195, 8'd25, 8'h77, 8'h88, 8'h99, 9'h100));
    pix_pending_q.push_back(make_pixel(8'd16, 8'd200, 8'd30, 8'hAA, 8'hBB, 8'hCC, 9'h000));
    pix_pending_q.push_back(make_pixel(8'd10, 8'd200, 8'd24, 8'hDD, 8'hEE, 8'hFF, 9'h000));
    wait_drained();
    // widest tolerance matches everything
    write_settings(MODE_KEY, 9'd128, 8'h00, 8'h00, 8'h00, 8'hFF, '0);
    pix_pending_q.push_back(make_pixel(8'hFF, 8'h80, 8'h00, 8'h01, 8'h02, 8'h03, 9'h000));
    wait_drained();
    // zero tolerance at the top of the range
    write_settings(MODE_KEY, 9'd128, 8'hFF, 8'hFF, 8'hFF, 8'h00, '0);
    pix_pending_q.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 9'h000));
    wait_drained();

    // unused mode: base passes, matte weight ignored
    write_settings(MODE_PASS, 9'd256, 8'h00, 8'h00, 8'h00, 8'h00, '0);
    pix_pending_q.push_back(make_pixel(8'h01, 8'h80, 8'hFE, 8'hFF, 8'h00, 8'hFF, 9'h1FF));
    pix_pending_q.push_back(make_pixel(8'hA5, 8'h5A, 8'h00, 8'h00, 8'hFF, 8'h00, 9'h101));
    wait_drained();

    // writes outside the map change nothing; mode write with junk upper bits
    reg_write(REG_COUNT, 32'h0000_0001);
    reg_write(REG_COUNT + 1, 32'hFFFF_FFFF);
    reg_write(REG_MODE, 32'hFFFF_FFF5);
    pix_pending_q.push_back(make_pixel(8'h40, 8'h40, 8'h40, 8'hC0, 8'hC0, 8'hC0, 9'd300));
    wait_drained();

    // random phases: each idling profile, each mode, fresh register values
    for (phase = 0; phase < N_PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      m = mode_t'((phase + phase / 4) % 4);
      case ($urandom_range(3))
        0: alpha = 9'd0;
        1: alpha = 9'd256;
        2: alpha = ALPHA_W'($urandom_range(511, 257));
        default: alpha = ALPHA_W'($urandom_range(255));
      endcase
      case ($urandom_range(3))
        0: tol = 8'd0;
        1: tol = 8'd255;
        default: tol = CHAN_W'($urandom_range(40));
      endcase
      write_settings(m, alpha, CHAN_W'($urandom_range(255)), CHAN_W'($urandom_range(255)),
                     CHAN_W'($urandom_range(255)), tol, $urandom);

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // halfway through, hold the source until the pipe is empty
        if (i == ITEMS_PER_PHASE / 2) wait_drained();
        px = PIX_IN_W'({$urandom, $urandom});
        if (m == MODE_MATTE) begin
          // mostly legal weights, some oversized
          if ($urandom_range(4) == 0) px.matte_alpha = ALPHA_W'($urandom_range(511, 257));
          else                        px.matte_alpha = ALPHA_W'($urandom_range(256));
        end
        if (m == MODE_KEY && $urandom_range(9) < 7) begin
          // steer most base pixels around the key colour
          px.base_red   = near_value(cfg_now.key_red, tol);
          px.base_green = near_value(cfg_now.key_green, tol);
          px.base_blue  = near_value(cfg_now.key_blue, tol);
        end
        pix_pending_q.push_back(px);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d pixel requests over %0d register settings, %0d results checked",
             n_sent, n_settings, n_checked);
    $display("summary: %0d results carried the alpha error flag, %0d mismatches",
             n_flagged, n_errors);
    if (n_errors == 0 && pix_expect_q.size() == 0) begin
      $display("tb_rgb_blend_matte_chromakey: clean");
    end else begin
      $display("tb_rgb_blend_matte_chromakey: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rbmc_pkg.sv
hw/rtl/rbmc_cfg.sv
hw/rtl/rbmc_mix.sv
hw/rtl/rgb_blend_matte_chromakey.sv
hw/rtl/rbmc_chk.sv
tb/sv/tb_rgb_blend_matte_chromakey.sv
